/* design/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rmq_pkg.sv */
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int ENTRY_W       = 16;
    localparam int VAL_W         = 17;
    localparam int QUOT_W        = 17;
    localparam int THR_W         = 15;
    localparam int OUT_W         = 16;
    localparam int PROD_W        = VAL_W + THR_W;
    localparam int SAT_MAX       = 32767;
    localparam int SAT_MIN_MAG   = 32768;

    typedef logic [1:0] t_axis;
    localparam t_axis AX_X     = 2'd0;
    localparam t_axis AX_Y     = 2'd1;
    localparam t_axis AX_Z     = 2'd2;
    localparam t_axis AX_TRACE = 2'd3;

    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef logic signed [VAL_W-1:0]   t_val;
    typedef logic signed [OUT_W-1:0]   t_out;

    // axis choice plus the three off-diagonal terms to be scaled
    typedef struct packed {
        t_axis ax;
        t_val  va;
        t_val  vb;
        t_val  vc;
    } t_lanes;

endpackage

/* design/rmq_front.sv */
module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int RAD_W     = 19
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  rmq_pkg::t_entry       i_m00,
    input  rmq_pkg::t_entry       i_m01,
    input  rmq_pkg::t_entry       i_m02,
    input  rmq_pkg::t_entry       i_m10,
    input  rmq_pkg::t_entry       i_m11,
    input  rmq_pkg::t_entry       i_m12,
    input  rmq_pkg::t_entry       i_m20,
    input  rmq_pkg::t_entry       i_m21,
    input  rmq_pkg::t_entry       i_m22,
    output logic                  o_valid,
    output logic [RAD_W-1:0]      o_rad,
    output rmq_pkg::t_lanes       o_lanes
);

    localparam int RS_W = RAD_W + 1;
    localparam int SUM_W = rmq_pkg::ENTRY_W + 2;
    localparam int BASE_W = rmq_pkg::ENTRY_W + 3;
    localparam logic signed [RS_W-1:0] ONE = RS_W'(1) << FRAC_BITS;

    logic signed [SUM_W-1:0]  c_tr;
    logic signed [BASE_W-1:0] c_base;
    logic signed [RS_W-1:0]   c_rad_s;
    rmq_pkg::t_entry          c_dmax;
    rmq_pkg::t_axis           c_ax;
    rmq_pkg::t_lanes          c_lanes;

    always_comb begin
        c_tr = SUM_W'(i_m00) + SUM_W'(i_m11) + SUM_W'(i_m22);
        c_dmax = (i_m11 > i_m00) ? i_m11 : i_m00;
        if (c_tr > 0) begin
            c_ax = rmq_pkg::AX_TRACE;
        end else if (i_m22 > c_dmax) begin
            c_ax = rmq_pkg::AX_Z;
        end else if (i_m11 > i_m00) begin
            c_ax = rmq_pkg::AX_Y;
        end else begin
            c_ax = rmq_pkg::AX_X;
        end

        c_lanes.ax = c_ax;
        unique case (c_ax)
            rmq_pkg::AX_X: begin
                c_base = BASE_W'(i_m00) - (BASE_W'(i_m11) + BASE_W'(i_m22));
                c_lanes.va = rmq_pkg::t_val'(i_m12) - rmq_pkg::t_val'(i_m21);
                c_lanes.vb = rmq_pkg::t_val'(i_m01) + rmq_pkg::t_val'(i_m10);
                c_lanes.vc = rmq_pkg::t_val'(i_m02) + rmq_pkg::t_val'(i_m20);
            end
            rmq_pkg::AX_Y: begin
                c_base = BASE_W'(i_m11) - (BASE_W'(i_m22) + BASE_W'(i_m00));
                c_lanes.va = rmq_pkg::t_val'(i_m20) - rmq_pkg::t_val'(i_m02);
                c_lanes.vb = rmq_pkg::t_val'(i_m12) + rmq_pkg::t_val'(i_m21);
                c_lanes.vc = rmq_pkg::t_val'(i_m10) + rmq_pkg::t_val'(i_m01);
            end
            rmq_pkg::AX_Z: begin
                c_base = BASE_W'(i_m22) - (BASE_W'(i_m00) + BASE_W'(i_m11));
                c_lanes.va = rmq_pkg::t_val'(i_m01) - rmq_pkg::t_val'(i_m10);
                c_lanes.vb = rmq_pkg::t_val'(i_m20) + rmq_pkg::t_val'(i_m02);
                c_lanes.vc = rmq_pkg::t_val'(i_m21) + rmq_pkg::t_val'(i_m12);
            end
            default: begin
                c_base = BASE_W'(c_tr);
                c_lanes.va = rmq_pkg::t_val'(i_m12) - rmq_pkg::t_val'(i_m21);
                c_lanes.vb = rmq_pkg::t_val'(i_m20) - rmq_pkg::t_val'(i_m02);
                c_lanes.vc = rmq_pkg::t_val'(i_m01) - rmq_pkg::t_val'(i_m10);
            end
        endcase
        c_rad_s = RS_W'(c_base) + ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // clamp a non-positive radicand to zero; the axis choice keeps it positive
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad   <= (c_rad_s <= 0) ? '0 : c_rad_s[RAD_W-1:0];
            o_lanes <= c_lanes;
        end
    end

endmodule

/* design/rmq_sqrt.sv */
module rmq_sqrt #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int RAD_W     = 19,
    parameter int ROOT_W    = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [RAD_W-1:0]    i_rad,
    input  rmq_pkg::t_lanes     i_lanes,
    output logic                o_valid,
    output logic [ROOT_W-1:0]   o_root,
    output rmq_pkg::t_lanes     o_lanes
);

    localparam int TW = 2 * ROOT_W + 1;

    logic [TW-1:0]     c_n;
    logic [TW-1:0]     r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    rmq_pkg::t_lanes   r_pl   [0:ROOT_W-1];
    logic              r_vld  [0:ROOT_W-1];

    assign c_n = TW'(i_rad) << FRAC_BITS;

    // one root bit per stage, msb first
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [TW-1:0]     c_rem_in;
        logic [TW-1:0]     c_t;
        logic [ROOT_W-1:0] c_root_in;
        rmq_pkg::t_lanes   c_pl_in;
        logic              c_vld_in;

        if (k == 0) begin : g_first
            assign c_rem_in  = c_n;
            assign c_root_in = '0;
            assign c_pl_in   = i_lanes;
            assign c_vld_in  = i_valid;
        end else begin : g_next
            assign c_rem_in  = r_rem[k-1];
            assign c_root_in = r_root[k-1];
            assign c_pl_in   = r_pl[k-1];
            assign c_vld_in  = r_vld[k-1];
        end

        // (root + 2^B)^2 - root^2
        assign c_t = (TW'(c_root_in) << (B + 1)) | (TW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= c_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (c_rem_in >= c_t) begin
                    r_rem[k]  <= c_rem_in - c_t;
                    r_root[k] <= c_root_in | (ROOT_W'(1) << B);
                end else begin
                    r_rem[k]  <= c_rem_in;
                    r_root[k] <= c_root_in;
                end
                r_pl[k] <= c_pl_in;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_lanes = r_pl[ROOT_W-1];

endmodule

/* design/rmq_lane.sv */
module rmq_lane #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int ROOT_W    = 17
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  rmq_pkg::t_val      i_v,
    input  logic [ROOT_W-1:0]  i_s,
    input  logic               i_recip,
    output rmq_pkg::t_out      o_q
);

    localparam int QB  = rmq_pkg::QUOT_W;
    localparam int VW  = rmq_pkg::VAL_W;
    localparam int PW  = rmq_pkg::PROD_W;
    localparam int NUM_W = VW + FRAC_BITS;
    localparam int DEN_W = ROOT_W + 1 + QB;
    localparam int CW  = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;

    logic [VW-1:0]     c_mag;
    logic [CW-1:0]     c_num;
    logic [CW-1:0]     c_den;
    logic [PW-1:0]     c_prod;
    logic [PW-1:0]     c_res;

    logic [CW-1:0]     r_rem   [0:QB];
    logic [ROOT_W:0]   r_den   [0:QB];
    logic [QB-1:0]     r_q     [0:QB];
    logic [PW-1:0]     r_prod  [0:QB];
    logic              r_neg   [0:QB];
    logic              r_recip [0:QB];
    logic              r_ovf   [0:QB];

    always_comb begin
        c_mag  = i_v[VW-1] ? VW'(-i_v) : VW'(i_v);
        c_num  = CW'(c_mag) << FRAC_BITS;
        c_den  = CW'({i_s, 1'b0});
        // only used when the root is at most the 15-bit threshold
        c_prod = PW'(c_mag) * PW'(i_s[rmq_pkg::THR_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]   <= c_num;
            r_den[0]   <= {i_s, 1'b0};
            r_q[0]     <= '0;
            r_prod[0]  <= c_prod;
            r_neg[0]   <= i_v[VW-1];
            r_recip[0] <= i_recip;
            r_ovf[0]   <= (c_num >= (c_den << QB));
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 1; k <= QB; k++) begin : g_div
        localparam int B = QB - k;
        logic [CW-1:0] c_sub;

        assign c_sub = CW'(r_den[k-1]) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[k-1] >= c_sub) begin
                    r_rem[k] <= r_rem[k-1] - c_sub;
                    r_q[k]   <= r_q[k-1] | (QB'(1) << B);
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_q[k]   <= r_q[k-1];
                end
                r_den[k]   <= r_den[k-1];
                r_prod[k]  <= r_prod[k-1];
                r_neg[k]   <= r_neg[k-1];
                r_recip[k] <= r_recip[k-1];
                r_ovf[k]   <= r_ovf[k-1];
            end
        end
    end

    always_comb begin
        if (r_recip[QB]) begin
            c_res = r_ovf[QB] ? (PW'(1) << QB) : PW'(r_q[QB]);
        end else begin
            c_res = r_prod[QB] >> FRAC_BITS;
        end
        if (r_neg[QB]) begin
            if (c_res >= PW'(rmq_pkg::SAT_MIN_MAG)) begin
                o_q = rmq_pkg::t_out'(-rmq_pkg::SAT_MIN_MAG);
            end else begin
                o_q = -rmq_pkg::t_out'(c_res[rmq_pkg::OUT_W-1:0]);
            end
        end else begin
            if (c_res > PW'(rmq_pkg::SAT_MAX)) begin
                o_q = rmq_pkg::t_out'(rmq_pkg::SAT_MAX);
            end else begin
                o_q = rmq_pkg::t_out'(c_res[rmq_pkg::OUT_W-1:0]);
            end
        end
    end

endmodule

/* design/rotation_matrix_to_quaternion_core.sv */
// channel   direction  handshake                     payload
// matrix    in         i_valid / o_stall             i_m00 .. i_m22, 16b signed each
// quat      out        o_valid / i_stall             o_quat_x/y/z/w, 16b signed each
// config    in         i_cfg_valid / o_cfg_ready     i_cfg_data, 15b root threshold
//
// one matrix per cycle unless a held output stalls the pipeline, which holds, in order:
// one front stage, one square-root stage per root bit, 18 divide/multiply stages
// and the output register. the root pipeline and the divide lanes set the depth.
// synchronous active-low reset clears valids and loads the threshold with 1.
// a held output freezes the whole pipeline; o_stall follows it combinationally.
`include "assert_macros.svh"

module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  rmq_pkg::t_entry               i_m00,
    input  rmq_pkg::t_entry               i_m01,
    input  rmq_pkg::t_entry               i_m02,
    input  rmq_pkg::t_entry               i_m10,
    input  rmq_pkg::t_entry               i_m11,
    input  rmq_pkg::t_entry               i_m12,
    input  rmq_pkg::t_entry               i_m20,
    input  rmq_pkg::t_entry               i_m21,
    input  rmq_pkg::t_entry               i_m22,
    output logic                          o_valid,
    input  logic                          i_stall,
    output rmq_pkg::t_out                 o_quat_x,
    output rmq_pkg::t_out                 o_quat_y,
    output rmq_pkg::t_out                 o_quat_z,
    output rmq_pkg::t_out                 o_quat_w,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rmq_pkg::THR_W-1:0]     i_cfg_data
);

    localparam int RAD_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int ROOT_W = (RAD_W + FRAC_BITS + 1) / 2;
    localparam int LD     = rmq_pkg::QUOT_W + 1;
    localparam int OW     = rmq_pkg::OUT_W;
    localparam int HALF_MIN = (FRAC_BITS > 15) ? rmq_pkg::SAT_MAX : (1 << (FRAC_BITS - 1));

    logic                       c_en;
    logic [rmq_pkg::THR_W-1:0]  r_thr;

    logic                       w_fr_vld;
    logic [RAD_W-1:0]           w_fr_rad;
    rmq_pkg::t_lanes            w_fr_lanes;

    logic                       w_sq_vld;
    logic [ROOT_W-1:0]          w_sq_root;
    rmq_pkg::t_lanes            w_sq_lanes;

    logic                       c_recip;
    logic [ROOT_W-1:0]          c_half_full;
    logic [OW-1:0]              c_half;

    rmq_pkg::t_out              w_qa;
    rmq_pkg::t_out              w_qb;
    rmq_pkg::t_out              w_qc;

    logic                       r_sb_vld  [0:LD-1];
    rmq_pkg::t_axis             r_sb_ax   [0:LD-1];
    logic [OW-1:0]              r_sb_half [0:LD-1];

    logic                       r_out_valid;
    rmq_pkg::t_out              r_qx;
    rmq_pkg::t_out              r_qy;
    rmq_pkg::t_out              r_qz;
    rmq_pkg::t_out              r_qw;
    rmq_pkg::t_out              c_half_s;

    assign c_en        = !r_out_valid || !i_stall;
    assign o_stall     = !c_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rmq_pkg::THR_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .RAD_W     (RAD_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (i_valid),
        .i_m00   (i_m00),
        .i_m01   (i_m01),
        .i_m02   (i_m02),
        .i_m10   (i_m10),
        .i_m11   (i_m11),
        .i_m12   (i_m12),
        .i_m20   (i_m20),
        .i_m21   (i_m21),
        .i_m22   (i_m22),
        .o_valid (w_fr_vld),
        .o_rad   (w_fr_rad),
        .o_lanes (w_fr_lanes)
    );

    rmq_sqrt #(
        .FRAC_BITS (FRAC_BITS),
        .RAD_W     (RAD_W),
        .ROOT_W    (ROOT_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (w_fr_vld),
        .i_rad   (w_fr_rad),
        .i_lanes (w_fr_lanes),
        .o_valid (w_sq_vld),
        .o_root  (w_sq_root),
        .o_lanes (w_sq_lanes)
    );

    // trace path always divides; the other paths divide only above the threshold
    assign c_recip     = (w_sq_lanes.ax == rmq_pkg::AX_TRACE) ||
                         (w_sq_root > ROOT_W'(r_thr));
    assign c_half_full = w_sq_root >> 1;
    assign c_half      = (c_half_full > ROOT_W'(rmq_pkg::SAT_MAX)) ?
                         OW'(rmq_pkg::SAT_MAX) : c_half_full[OW-1:0];

    rmq_lane #(.FRAC_BITS(FRAC_BITS), .ROOT_W(ROOT_W)) u_lane_a (
        .i_clk   (i_clk),
        .i_en    (c_en),
        .i_v     (w_sq_lanes.va),
        .i_s     (w_sq_root),
        .i_recip (c_recip),
        .o_q     (w_qa)
    );

    rmq_lane #(.FRAC_BITS(FRAC_BITS), .ROOT_W(ROOT_W)) u_lane_b (
        .i_clk   (i_clk),
        .i_en    (c_en),
        .i_v     (w_sq_lanes.vb),
        .i_s     (w_sq_root),
        .i_recip (c_recip),
        .o_q     (w_qb)
    );

    rmq_lane #(.FRAC_BITS(FRAC_BITS), .ROOT_W(ROOT_W)) u_lane_c (
        .i_clk   (i_clk),
        .i_en    (c_en),
        .i_v     (w_sq_lanes.vc),
        .i_s     (w_sq_root),
        .i_recip (c_recip),
        .o_q     (w_qc)
    );

    // axis and half-root ride alongside the divide lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LD; k++) begin
                r_sb_vld[k] <= 1'b0;
            end
        end else if (c_en) begin
            r_sb_vld[0] <= w_sq_vld;
            for (int k = 1; k < LD; k++) begin
                r_sb_vld[k] <= r_sb_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_sb_ax[0]   <= w_sq_lanes.ax;
            r_sb_half[0] <= c_half;
            for (int k = 1; k < LD; k++) begin
                r_sb_ax[k]   <= r_sb_ax[k-1];
                r_sb_half[k] <= r_sb_half[k-1];
            end
        end
    end

    assign c_half_s = rmq_pkg::t_out'(r_sb_half[LD-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_en) begin
            r_out_valid <= r_sb_vld[LD-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            case (r_sb_ax[LD-1])
                rmq_pkg::AX_X: begin
                    r_qx <= c_half_s;
                    r_qy <= w_qb;
                    r_qz <= w_qc;
                    r_qw <= w_qa;
                end
                rmq_pkg::AX_Y: begin
                    r_qx <= w_qc;
                    r_qy <= c_half_s;
                    r_qz <= w_qb;
                    r_qw <= w_qa;
                end
                rmq_pkg::AX_Z: begin
                    r_qx <= w_qb;
                    r_qy <= w_qc;
                    r_qz <= c_half_s;
                    r_qw <= w_qa;
                end
                default: begin
                    r_qx <= w_qa;
                    r_qy <= w_qb;
                    r_qz <= w_qc;
                    r_qw <= c_half_s;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;
    assign o_quat_w = r_qw;

    `ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, w_fr_vld, "accepted matrix did not enter the front stage")
    `ASSERT_NEXT(a_hold_freezes, i_clk, i_rst_n, r_out_valid && i_stall, $stable(r_sb_vld[LD-1]), "pipeline moved while output was held")
    `ASSERT_IMPL(a_trace_root, i_clk, i_rst_n, r_sb_vld[LD-1] && (r_sb_ax[LD-1] == rmq_pkg::AX_TRACE), r_sb_half[LD-1] >= OW'(HALF_MIN), "trace-path root below one")

endmodule

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE = 1 << rmq_pkg::FRAC_BITS_DEF;
    localparam int LIMIT = 2000000;

    typedef struct {
        rmq_pkg::t_out x;
        rmq_pkg::t_out y;
        rmq_pkg::t_out z;
        rmq_pkg::t_out w;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    rmq_pkg::t_entry mat_in [9];
    logic o_valid;
    logic i_stall = 1'b0;
    rmq_pkg::t_out o_quat_x, o_quat_y, o_quat_z, o_quat_w;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [rmq_pkg::THR_W-1:0] i_cfg_data = '0;

    longint unsigned thresh_q;
    t_quat expected_quats[$];
    int errors = 0;
    longint cycles = 0;
    bit stim_done = 1'b0;

    initial for (int n = 0; n < 9; n++) mat_in[n] = '0;

    always #2 i_clk = ~i_clk;

    rotation_matrix_to_quaternion_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_m00(mat_in[0]), .i_m01(mat_in[1]), .i_m02(mat_in[2]),
        .i_m10(mat_in[3]), .i_m11(mat_in[4]), .i_m12(mat_in[5]),
        .i_m20(mat_in[6]), .i_m21(mat_in[7]), .i_m22(mat_in[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_quat_x(o_quat_x), .o_quat_y(o_quat_y), .o_quat_z(o_quat_z),
        .o_quat_w(o_quat_w),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    function automatic longint int_root(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint root_of(longint r);
        if (r <= 0) return 0;
        return int_root(longint'(r) << rmq_pkg::FRAC_BITS_DEF);
    endfunction

    function automatic rmq_pkg::t_out clip16(longint v);
        if (v > rmq_pkg::SAT_MAX) return rmq_pkg::t_out'(rmq_pkg::SAT_MAX);
        if (v < -rmq_pkg::SAT_MIN_MAG) return rmq_pkg::t_out'(-rmq_pkg::SAT_MIN_MAG);
        return rmq_pkg::t_out'(v);
    endfunction

    // 0.5/s scaling or multiply by s, both truncate toward zero
    function automatic longint scale_term(longint v, longint s, bit by_recip);
        if (by_recip) return (v * ONE) / (2 * s);
        return (v * s) / ONE;
    endfunction

    function automatic t_quat matrix_to_quat(rmq_pkg::t_entry e [9]);
        longint m [3][3];
        longint q [4];
        longint tr, s;
        int i, j, k;
        bit by_recip;
        t_quat res;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) m[r][c] = longint'(e[r*3+c]);
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            s = root_of(tr + ONE);
            q[3] = s >>> 1;
            q[0] = scale_term(m[1][2] - m[2][1], s, 1'b1);
            q[1] = scale_term(m[2][0] - m[0][2], s, 1'b1);
            q[2] = scale_term(m[0][1] - m[1][0], s, 1'b1);
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            s = root_of(m[i][i] - (m[j][j] + m[k][k]) + ONE);
            q[i] = s >>> 1;
            by_recip = longint'(s) > longint'(thresh_q);
            q[3] = scale_term(m[j][k] - m[k][j], s, by_recip);
            q[j] = scale_term(m[i][j] + m[j][i], s, by_recip);
            q[k] = scale_term(m[i][k] + m[k][i], s, by_recip);
        end
        res.x = clip16(q[0]);
        res.y = clip16(q[1]);
        res.z = clip16(q[2]);
        res.w = clip16(q[3]);
        return res;
    endfunction

    function automatic int rand_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side: random stall, check on each transfer
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_quats.size() == 0) begin
                $error("quat transfer with nothing expected");
                errors++;
            end else begin
                t_quat ex;
                ex = expected_quats.pop_front();
                if (o_quat_x !== ex.x) begin
                    $error("quat_x expected %0d actual %0d", ex.x, o_quat_x); errors++;
                end
                if (o_quat_y !== ex.y) begin
                    $error("quat_y expected %0d actual %0d", ex.y, o_quat_y); errors++;
                end
                if (o_quat_z !== ex.z) begin
                    $error("quat_z expected %0d actual %0d", ex.z, o_quat_z); errors++;
                end
                if (o_quat_w !== ex.w) begin
                    $error("quat_w expected %0d actual %0d", ex.w, o_quat_w); errors++;
                end
            end
        end
    end

    bit stall_on = 1'b1;
    int stall_len = 0;
    always @(negedge i_clk) begin
        if (!stall_on) begin
            i_stall <= 1'b0;
        end else if (stall_len > 0) begin
            stall_len <= stall_len - 1;
            i_stall <= 1'b1;
        end else begin
            int g;
            g = rand_gap();
            stall_len <= (g > 0) ? g - 1 : 0;
            i_stall <= (g > 0);
        end
    end

    initial begin
        wait (cycles >= LIMIT);
        $display("tb: failure");
        $finish;
    end

    // valid stays up after a transfer until the next item or a gap lowers it
    task automatic send_matrix(rmq_pkg::t_entry e [9]);
        int g;
        g = rand_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        for (int n = 0; n < 9; n++) mat_in[n] <= e[n];
        i_valid <= 1'b1;
        expected_quats.push_back(matrix_to_quat(e));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_quats.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [rmq_pkg::THR_W-1:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        thresh_q = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic rmq_pkg::t_entry rand_entry();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return rmq_pkg::t_entry'(-32768);
        if (p == 1) return rmq_pkg::t_entry'(32767);
        if (p < 5) return rmq_pkg::t_entry'($urandom_range(0, 2 * ONE) - ONE);
        return rmq_pkg::t_entry'($urandom);
    endfunction

    // near-rotation matrix: signed permutation with jitter, hits every axis
    task automatic send_rotation_like();
        rmq_pkg::t_entry e [9];
        int perm [3];
        int a;
        perm = '{0, 1, 2};
        for (int n = 2; n > 0; n--) begin
            int r, t;
            r = $urandom_range(0, n);
            t = perm[n]; perm[n] = perm[r]; perm[r] = t;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
                a = (perm[r] == c) ? ($urandom_range(0, 1) ? ONE : -ONE) : 0;
                a += $urandom_range(0, 8000) - 4000;
                e[r*3+c] = rmq_pkg::t_entry'(a);
            end
        send_matrix(e);
    endtask

    task automatic send_random_matrix();
        rmq_pkg::t_entry e [9];
        for (int n = 0; n < 9; n++) e[n] = rand_entry();
        send_matrix(e);
    endtask

    task automatic test_directed();
        rmq_pkg::t_entry e [9];
        // identity, positive trace
        e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
        send_matrix(e);
        // 180 deg about each axis and the zero matrix, non-trace paths and ties
        e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}; send_matrix(e);
        e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}; send_matrix(e);
        e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}; send_matrix(e);
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(e);
        // strongly negative diagonals
        e = '{-100, 5, 6, 7, 8000, 9, 10, 11, 9000};
        e[0] = -32768; e[4] = -30000; e[8] = 32767 - 32767; send_matrix(e);
        e = '{-20000, 100, 200, 300, -20000, 400, 500, 600, -20000}; send_matrix(e);
        // extremes everywhere
        for (int n = 0; n < 9; n++) e[n] = rmq_pkg::t_entry'(-32768);
        send_matrix(e);
        for (int n = 0; n < 9; n++) e[n] = rmq_pkg::t_entry'(32767);
        send_matrix(e);
        e = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
        send_matrix(e);
        e = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
        send_matrix(e);
        // small root path with saturating products
        e = '{-16384, 32767, 32767, 32767, -16384, -32768, 32767, 32767, -16384};
        send_matrix(e);
        e = '{0, 32767, -32768, -32768, -1, 32767, 32767, -32768, -1}; send_matrix(e);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
            if ($urandom_range(0, 9) < 6) send_rotation_like();
            else send_random_matrix();
    endtask

    // no stalls and no gaps for a stretch
    task automatic test_back_to_back(int count);
        stall_on = 1'b0;
        for (int n = 0; n < count; n++) begin
            rmq_pkg::t_entry e [9];
            for (int c = 0; c < 9; c++) e[c] = rmq_pkg::t_entry'($urandom);
            for (int c = 0; c < 9; c++) mat_in[c] <= e[c];
            i_valid <= 1'b1;
            expected_quats.push_back(matrix_to_quat(e));
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            @(negedge i_clk);
        end
        stall_on = 1'b1;
    endtask

    initial begin
        thresh_q = 1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        write_threshold(15'd0);
        test_directed();
        write_threshold(15'h7FFF);
        test_directed();
        test_random(250);
        write_threshold(15'd16384);
        test_random(250);
        write_threshold(15'd1);
        test_random(300);
        test_back_to_back(200);
        write_threshold(15'($urandom_range(2, 32766)));
        test_random(250);
        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+design
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_sqrt.sv
design/rmq_lane.sv
design/rotation_matrix_to_quaternion_core.sv
tb/sv/tb.sv
